/* rtl/core/rhmm_pkg.sv */
// shared constants and controller/datapath interface types for the rgb histogram block
`default_nettype none

package rhmm_pkg;

    localparam int BIN_COUNT   = 256;
    localparam int BIN_AW      = $clog2(BIN_COUNT);
    localparam int BIN_W       = 25;
    localparam int SUM_W       = BIN_W + 1;
    localparam int MEAN_W      = 17;
    localparam int MED_W       = 8;
    localparam int PIX_W       = 8;
    localparam int RECIP_W     = 32;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 33;
    localparam int MEAN_SHIFT  = 8;
    localparam int NCOLOR      = 3;
    localparam int NCH         = 4;

    localparam logic [BIN_W-1:0]   MAX_PIXELS = 25'd16777216;
    // ceil(2^33 / 3): x * RECIP3 >> 33 is x / 3 for any 32-bit x
    localparam logic [RECIP_W-1:0] RECIP3     = 32'hAAAA_AAAB;

    // histogram slots for totals and medians
    localparam int CH_LUM   = 0;
    localparam int CH_RED   = 1;
    localparam int CH_GREEN = 2;
    localparam int CH_BLUE  = 3;

    typedef struct packed {
        logic              clr_wr;
        logic              pix_rd;
        logic              pix_wr;
        logic              sum_rd;
        logic              med_rd;
        logic              load;
        logic [BIN_AW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
        logic last;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/rhmm_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module rhmm_ram #(
    parameter int WIDTH = rhmm_pkg::BIN_W,
    parameter int DEPTH = rhmm_pkg::BIN_COUNT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/rhmm_ctrl.sv */
// sequencer for clearing, pixel counting, sum pass, median pass and result load
`default_nettype none

module rhmm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire rhmm_pkg::t_sts i_sts,
    output rhmm_pkg::t_cmd      o_cmd
);

    localparam int IW = rhmm_pkg::BIN_AW + 1;
    localparam logic [rhmm_pkg::BIN_AW-1:0] LAST_BIN =
        rhmm_pkg::BIN_AW'(rhmm_pkg::BIN_COUNT - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_BUMP  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_MED   = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.addr = r_idx[rhmm_pkg::BIN_AW-1:0];
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                n_idx        = r_idx + IW'(1);
                if (r_idx[rhmm_pkg::BIN_AW-1:0] == LAST_BIN) begin
                    n_state = ST_IDLE;
                    n_idx   = '0;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.pix_rd = 1'b1;
                    n_state      = ST_BUMP;
                end
            end
            ST_BUMP: begin
                o_cmd.pix_wr = 1'b1;
                n_idx        = '0;
                n_state      = i_sts.last ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                if (!r_idx[rhmm_pkg::BIN_AW]) begin
                    o_cmd.sum_rd = 1'b1;
                    n_idx        = r_idx + IW'(1);
                end else if (!i_sts.busy) begin
                    // lum store fully written once the pipe drains
                    n_state = ST_MED;
                    n_idx   = '0;
                end
            end
            ST_MED: begin
                if (!r_idx[rhmm_pkg::BIN_AW]) begin
                    o_cmd.med_rd = 1'b1;
                    n_idx        = r_idx + IW'(1);
                end else if (!i_sts.busy) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr_wr, o_cmd.pix_rd, o_cmd.pix_wr,
                  o_cmd.sum_rd, o_cmd.med_rd, o_cmd.load}))
        else $error("more than one datapath command at once");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.out_free)
        else $error("result load while output register still full");
`endif

endmodule

`default_nettype wire

/* rtl/core/rhmm_dp.sv */
// histogram stores, bin update, luminosity/total pipeline, median search and result register
`default_nettype none

module rhmm_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [rhmm_pkg::PIX_W-1:0]     i_pixel_red,
    input  wire logic [rhmm_pkg::PIX_W-1:0]     i_pixel_green,
    input  wire logic [rhmm_pkg::PIX_W-1:0]     i_pixel_blue,
    input  wire logic                           i_last_pixel,
    input  wire rhmm_pkg::t_cmd                 i_cmd,
    output rhmm_pkg::t_sts                      o_sts,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output logic      [rhmm_pkg::MEAN_W-1:0]    o_mean_lum,
    output logic      [rhmm_pkg::MEAN_W-1:0]    o_mean_red,
    output logic      [rhmm_pkg::MEAN_W-1:0]    o_mean_green,
    output logic      [rhmm_pkg::MEAN_W-1:0]    o_mean_blue,
    output logic      [rhmm_pkg::MED_W-1:0]     o_median_lum,
    output logic      [rhmm_pkg::MED_W-1:0]     o_median_red,
    output logic      [rhmm_pkg::MED_W-1:0]     o_median_green,
    output logic      [rhmm_pkg::MED_W-1:0]     o_median_blue,
    output logic      [rhmm_pkg::BIN_W-1:0]     o_pixel_total
);

    localparam int AW  = rhmm_pkg::BIN_AW;
    localparam int BW  = rhmm_pkg::BIN_W;
    localparam int NC  = rhmm_pkg::NCOLOR;
    localparam int NCH = rhmm_pkg::NCH;

    // color stores: index 0 red, 1 green, 2 blue
    logic [rhmm_pkg::PIX_W-1:0] w_pix_in [NC];
    logic [rhmm_pkg::PIX_W-1:0] r_pix    [NC];
    logic [BW-1:0]              w_crd    [NC];
    logic [AW-1:0]              w_craddr [NC];
    logic [AW-1:0]              w_cwaddr [NC];
    logic [BW-1:0]              w_cwdata [NC];
    logic                       w_cwe    [NC];
    logic                       r_last;

    logic [BW-1:0] w_lrd;
    logic [BW-1:0] w_lum;

    logic [BW-1:0] r_count;
    logic          w_cnt_ok;

    // scan pipeline
    logic                        r_s1;
    logic                        r_m1;
    logic                        r_v2;
    logic                        r_v3;
    logic [AW-1:0]               r_idx1;
    logic [AW-1:0]               r_idx2;
    logic [AW-1:0]               r_idx3;
    logic [rhmm_pkg::SUM_W-1:0]  w_sum;
    logic [rhmm_pkg::SUM_W-1:0]  r_sum;
    logic [rhmm_pkg::PROD_W-1:0] w_prod;
    logic [rhmm_pkg::PROD_W-1:0] r_prod;

    // per histogram: lum, red, green, blue
    logic [BW-1:0]              w_bin   [NCH];
    logic [BW-1:0]              r_tot   [NCH];
    logic [BW-1:0]              r_run   [NCH];
    logic [BW-1:0]              w_run_n [NCH];
    logic                       w_hit   [NCH];
    logic                       r_found [NCH];
    logic [rhmm_pkg::MED_W-1:0] r_med   [NCH];

    logic                          r_out_valid;
    logic [rhmm_pkg::MEAN_W-1:0]   r_omean [NCH];
    logic [rhmm_pkg::MED_W-1:0]    r_omed  [NCH];
    logic [BW-1:0]                 r_ototal;

    assign w_pix_in[0] = i_pixel_red;
    assign w_pix_in[1] = i_pixel_green;
    assign w_pix_in[2] = i_pixel_blue;

    assign w_cnt_ok = (r_count < rhmm_pkg::MAX_PIXELS);

    for (genvar c = 0; c < NC; c++) begin : g_color
        // zero write during the median pass clears the bin behind the scan
        assign w_craddr[c] = i_cmd.pix_rd ? w_pix_in[c] : i_cmd.addr;
        assign w_cwe[c]    = i_cmd.clr_wr | r_m1 |
                             (i_cmd.pix_wr & w_cnt_ok & (w_crd[c] < rhmm_pkg::MAX_PIXELS));
        assign w_cwaddr[c] = i_cmd.pix_wr ? r_pix[c] : (r_m1 ? r_idx1 : i_cmd.addr);
        assign w_cwdata[c] = i_cmd.pix_wr ? (w_crd[c] + BW'(1)) : '0;

        rhmm_ram #(
            .WIDTH (BW),
            .DEPTH (rhmm_pkg::BIN_COUNT)
        ) u_bins (
            .i_clk   (i_clk),
            .i_we    (w_cwe[c]),
            .i_waddr (w_cwaddr[c]),
            .i_wdata (w_cwdata[c]),
            .i_raddr (w_craddr[c]),
            .o_rdata (w_crd[c])
        );

        assign w_bin[c + 1] = w_crd[c];
    end

    assign w_sum  = rhmm_pkg::SUM_W'(w_crd[0]) + rhmm_pkg::SUM_W'(w_crd[1])
                  + rhmm_pkg::SUM_W'(w_crd[2]);
    assign w_prod = r_sum * rhmm_pkg::RECIP3;
    assign w_lum  = r_prod[rhmm_pkg::PROD_W-1:rhmm_pkg::RECIP_SHIFT];

    rhmm_ram #(
        .WIDTH (BW),
        .DEPTH (rhmm_pkg::BIN_COUNT)
    ) u_lum_bins (
        .i_clk   (i_clk),
        .i_we    (r_v3),
        .i_waddr (r_idx3),
        .i_wdata (w_lum),
        .i_raddr (i_cmd.addr),
        .o_rdata (w_lrd)
    );

    assign w_bin[rhmm_pkg::CH_LUM] = w_lrd;

    for (genvar h = 0; h < NCH; h++) begin : g_med
        assign w_run_n[h] = r_run[h] + w_bin[h];
        // exact form of running sum reaching half the total
        assign w_hit[h]   = ({w_run_n[h], 1'b0} >= {1'b0, r_tot[h]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= 1'b0;
            r_m1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int h = 0; h < NCH; h++) begin
                r_tot[h]   <= '0;
                r_run[h]   <= '0;
                r_found[h] <= 1'b0;
            end
        end else begin
            r_s1 <= i_cmd.sum_rd;
            r_m1 <= i_cmd.med_rd;
            r_v2 <= r_s1;
            r_v3 <= r_v2;

            if (i_cmd.load) begin
                r_count <= '0;
            end else if (i_cmd.pix_wr && w_cnt_ok) begin
                r_count <= r_count + BW'(1);
            end

            for (int h = 0; h < NCH; h++) begin
                if (i_cmd.load) begin
                    r_tot[h]   <= '0;
                    r_run[h]   <= '0;
                    r_found[h] <= 1'b0;
                end else begin
                    if (h == rhmm_pkg::CH_LUM) begin
                        if (r_v3) begin
                            r_tot[h] <= r_tot[h] + w_lum;
                        end
                    end else if (r_s1) begin
                        r_tot[h] <= r_tot[h] + w_bin[h];
                    end
                    if (r_m1) begin
                        r_run[h] <= w_run_n[h];
                        if (w_hit[h]) begin
                            r_found[h] <= 1'b1;
                        end
                    end
                end
            end

            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_rd) begin
            for (int c = 0; c < NC; c++) begin
                r_pix[c] <= w_pix_in[c];
            end
            r_last <= i_last_pixel;
        end
        r_idx1 <= i_cmd.addr;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_sum  <= w_sum;
        r_prod <= w_prod;
        for (int h = 0; h < NCH; h++) begin
            if (r_m1 && !r_found[h] && w_hit[h]) begin
                r_med[h] <= r_idx1;
            end
        end
        if (i_cmd.load) begin
            for (int h = 0; h < NCH; h++) begin
                r_omean[h] <= r_tot[h][BW-1:rhmm_pkg::MEAN_SHIFT];
                r_omed[h]  <= r_med[h];
            end
            r_ototal <= r_count;
        end
    end

    assign o_sts.busy     = r_s1 | r_m1 | r_v2 | r_v3;
    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_sts.last     = r_last;

    assign o_valid        = r_out_valid;
    assign o_mean_lum     = r_omean[rhmm_pkg::CH_LUM];
    assign o_mean_red     = r_omean[rhmm_pkg::CH_RED];
    assign o_mean_green   = r_omean[rhmm_pkg::CH_GREEN];
    assign o_mean_blue    = r_omean[rhmm_pkg::CH_BLUE];
    assign o_median_lum   = r_omed[rhmm_pkg::CH_LUM];
    assign o_median_red   = r_omed[rhmm_pkg::CH_RED];
    assign o_median_green = r_omed[rhmm_pkg::CH_GREEN];
    assign o_median_blue  = r_omed[rhmm_pkg::CH_BLUE];
    assign o_pixel_total  = r_ototal;

`ifndef SYNTHESIS
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rhmm_pkg::MAX_PIXELS)
        else $error("pixel counter above its saturation value");

    a_all_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_found[0] && r_found[1] && r_found[2] && r_found[3]))
        else $error("result loaded before every median was found");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> o_valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

/* rtl/core/rgb_histogram_mean_median.sv */
// top level: per-image rgb histogram totals, means and medians
//
//  channel | dir | handshake          | beat contents
//  pixel   | in  | i_valid / o_stall  | red, green, blue bytes and last flag
//  result  | out | o_valid / i_stall  | four means, four medians, pixel total
//
// each pixel beat is a read then a write back of the three bin rams
// a beat with the last flag starts a 256-bin sum pass feeding
// the divide-by-3 multiplier, then a 256-bin median pass that also zeroes bins
// after reset a clearing pass over all 256 bins runs with o_stall high
// a finished result waits in the output register while new pixels come in;
// the next image's scan holds its result until that register is taken
`default_nettype none

module rgb_histogram_mean_median (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [rhmm_pkg::PIX_W-1:0]   i_pixel_red,
    input  wire logic [rhmm_pkg::PIX_W-1:0]   i_pixel_green,
    input  wire logic [rhmm_pkg::PIX_W-1:0]   i_pixel_blue,
    input  wire logic                         i_last_pixel,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [rhmm_pkg::MEAN_W-1:0]  o_mean_lum,
    output logic      [rhmm_pkg::MEAN_W-1:0]  o_mean_red,
    output logic      [rhmm_pkg::MEAN_W-1:0]  o_mean_green,
    output logic      [rhmm_pkg::MEAN_W-1:0]  o_mean_blue,
    output logic      [rhmm_pkg::MED_W-1:0]   o_median_lum,
    output logic      [rhmm_pkg::MED_W-1:0]   o_median_red,
    output logic      [rhmm_pkg::MED_W-1:0]   o_median_green,
    output logic      [rhmm_pkg::MED_W-1:0]   o_median_blue,
    output logic      [rhmm_pkg::BIN_W-1:0]   o_pixel_total
);

    rhmm_pkg::t_cmd w_cmd;
    rhmm_pkg::t_sts w_sts;

    rhmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rhmm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .i_last_pixel   (i_last_pixel),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_mean_lum     (o_mean_lum),
        .o_mean_red     (o_mean_red),
        .o_mean_green   (o_mean_green),
        .o_mean_blue    (o_mean_blue),
        .o_median_lum   (o_median_lum),
        .o_median_red   (o_median_red),
        .o_median_green (o_median_green),
        .o_median_blue  (o_median_blue),
        .o_pixel_total  (o_pixel_total)
    );

endmodule

`default_nettype wire

/* tb/sv/rgb_histogram_mean_median_test.sv */
// testbench for rgb_histogram_mean_median: random images checked against a per-image stats predictor
`timescale 1ns / 1ps

module rgb_histogram_mean_median_test;

    import rhmm_pkg::*;

    localparam int PIXEL_BUDGET = 1400;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 1000;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_GRAY
    } t_spread;

    typedef struct packed {
        logic [NCH-1:0][MEAN_W-1:0] mean;
        logic [NCH-1:0][MED_W-1:0]  median;
        logic [BIN_W-1:0]           total;
    } t_image_stats;

    class image_stats_board;
        int unsigned  red_hist   [BIN_COUNT];
        int unsigned  green_hist [BIN_COUNT];
        int unsigned  blue_hist  [BIN_COUNT];
        int unsigned  pixel_count;
        t_image_stats stats_q[$];
        bit           failed;
        string        chan_name [NCH];

        function new();
            failed = 0;
            chan_name[CH_LUM]   = "lum";
            chan_name[CH_RED]   = "red";
            chan_name[CH_GREEN] = "green";
            chan_name[CH_BLUE]  = "blue";
            clear_image();
        endfunction

        function void clear_image();
            for (int i = 0; i < BIN_COUNT; i++) begin
                red_hist[i]   = 0;
                green_hist[i] = 0;
                blue_hist[i]  = 0;
            end
            pixel_count = 0;
        endfunction

        // count one accepted pixel; on the last one, work out the image's stats
        function void note_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                 input logic [PIX_W-1:0] b, input logic last);
            int unsigned     hist [NCH][BIN_COUNT];
            int unsigned     total;
            longint unsigned run;
            bit              found;
            t_image_stats    want;
            if (pixel_count < MAX_PIXELS) begin
                red_hist[r]++;
                green_hist[g]++;
                blue_hist[b]++;
                pixel_count++;
            end
            if (!last) return;
            for (int i = 0; i < BIN_COUNT; i++) begin
                hist[CH_RED][i]   = red_hist[i];
                hist[CH_GREEN][i] = green_hist[i];
                hist[CH_BLUE][i]  = blue_hist[i];
                hist[CH_LUM][i]   = (red_hist[i] + green_hist[i] + blue_hist[i]) / 3;
            end
            want = '0;
            for (int ch = 0; ch < NCH; ch++) begin
                total = 0;
                for (int i = 0; i < BIN_COUNT; i++) total += hist[ch][i];
                want.mean[ch] = MEAN_W'(total >> MEAN_SHIFT);
                // empty histogram leaves median at zero
                run   = 0;
                found = 0;
                if (total != 0) begin
                    for (int i = 0; i < BIN_COUNT; i++) begin
                        if (!found) begin
                            run += hist[ch][i];
                            if (2 * run >= total) begin
                                want.median[ch] = MED_W'(i);
                                found = 1;
                            end
                        end
                    end
                end
            end
            want.total = BIN_W'(pixel_count);
            stats_q.push_back(want);
            clear_image();
        endfunction

        function void check_field(input string what, input int unsigned want,
                                  input int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                failed = 1;
            end
        endfunction

        function void check_result(input t_image_stats got);
            t_image_stats want;
            if (stats_q.size() == 0) begin
                $display("%0t: unexpected result beat, actual total %0d", $time, got.total);
                failed = 1;
                return;
            end
            want = stats_q.pop_front();
            for (int ch = 0; ch < NCH; ch++) begin
                check_field({"mean_", chan_name[ch]}, want.mean[ch], got.mean[ch]);
                check_field({"median_", chan_name[ch]}, want.median[ch], got.median[ch]);
            end
            check_field("pixel_total", want.total, got.total);
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic [PIX_W-1:0]   i_pixel_red    = '0;
    logic [PIX_W-1:0]   i_pixel_green  = '0;
    logic [PIX_W-1:0]   i_pixel_blue   = '0;
    logic               i_last_pixel   = 1'b0;
    logic               i_stall        = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [MEAN_W-1:0]  o_mean_lum;
    logic [MEAN_W-1:0]  o_mean_red;
    logic [MEAN_W-1:0]  o_mean_green;
    logic [MEAN_W-1:0]  o_mean_blue;
    logic [MED_W-1:0]   o_median_lum;
    logic [MED_W-1:0]   o_median_red;
    logic [MED_W-1:0]   o_median_green;
    logic [MED_W-1:0]   o_median_blue;
    logic [BIN_W-1:0]   o_pixel_total;

    image_stats_board stats_board = new();
    t_image_stats     seen_stats;
    int unsigned      cycle_count  = 0;
    int unsigned      pixels_sent  = 0;
    bit               calm         = 0;

    rgb_histogram_mean_median i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .i_last_pixel   (i_last_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mean_lum     (o_mean_lum),
        .o_mean_red     (o_mean_red),
        .o_mean_green   (o_mean_green),
        .o_mean_blue    (o_mean_blue),
        .o_median_lum   (o_median_lum),
        .o_median_red   (o_median_red),
        .o_median_green (o_median_green),
        .o_median_blue  (o_median_blue),
        .o_pixel_total  (o_pixel_total)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check each beat taken, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_stats.mean[CH_LUM]     = o_mean_lum;
            seen_stats.mean[CH_RED]     = o_mean_red;
            seen_stats.mean[CH_GREEN]   = o_mean_green;
            seen_stats.mean[CH_BLUE]    = o_mean_blue;
            seen_stats.median[CH_LUM]   = o_median_lum;
            seen_stats.median[CH_RED]   = o_median_red;
            seen_stats.median[CH_GREEN] = o_median_green;
            seen_stats.median[CH_BLUE]  = o_median_blue;
            seen_stats.total            = o_pixel_total;
            stats_board.check_result(seen_stats);
        end
        i_stall <= !calm && ($urandom_range(99) < 34);
    end

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic last);
        while (!calm && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_red   <= r;
        i_pixel_green <= g;
        i_pixel_blue  <= b;
        i_last_pixel  <= last;
        do @(posedge i_clk); while (o_stall);
        stats_board.note_pixel(r, g, b, last);
        pixels_sent++;
    endtask

    function automatic logic [PIX_W-1:0] pick_byte(input t_spread spread,
                                                   input logic [PIX_W-1:0] base);
        if (spread == SPREAD_FULL) return PIX_W'($urandom_range(255));
        return PIX_W'(base + $urandom_range(7));
    endfunction

    task automatic send_image(input int unsigned n_pixels, input t_spread spread);
        logic [PIX_W-1:0] base_r, base_g, base_b, r, g, b;
        base_r = PIX_W'($urandom_range(255));
        base_g = PIX_W'($urandom_range(255));
        base_b = PIX_W'($urandom_range(255));
        for (int unsigned k = 0; k < n_pixels; k++) begin
            r = pick_byte(spread, base_r);
            if (spread == SPREAD_GRAY) begin
                g = r;
                b = r;
            end else begin
                g = pick_byte(spread, base_g);
                b = pick_byte(spread, base_b);
            end
            send_pixel(r, g, b, k == n_pixels - 1);
        end
    endtask

    initial begin
        int unsigned n_pixels;
        int unsigned roll;
        t_spread     spread;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-pixel images at the byte extremes
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        // distinct colors in one pixel: every lum bin floors to zero
        send_pixel(8'h00, 8'hFF, 8'h80, 1'b1);
        send_pixel(8'h01, 8'h02, 8'h03, 1'b1);
        // two gray pixels: median lands on the lower one
        send_pixel(8'h0A, 8'h0A, 8'h0A, 1'b0);
        send_pixel(8'h14, 8'h14, 8'h14, 1'b1);
        // alternating bit patterns
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        send_pixel(8'hAA, 8'hAA, 8'h55, 1'b1);
        // skewed image: median pulled to the repeated bin
        send_pixel(8'hFF, 8'h00, 8'h7F, 1'b0);
        send_pixel(8'h10, 8'h10, 8'h10, 1'b0);
        send_pixel(8'h10, 8'h10, 8'h10, 1'b0);
        send_pixel(8'h10, 8'h10, 8'h10, 1'b0);
        send_pixel(8'h80, 8'hFE, 8'h01, 1'b1);

        while (pixels_sent < PIXEL_BUDGET) begin
            calm = (pixels_sent >= 500) && (pixels_sent < 800);
            roll = $urandom_range(99);
            if (roll < 80)      n_pixels = $urandom_range(24, 1);
            else if (roll < 95) n_pixels = $urandom_range(60, 25);
            else                n_pixels = $urandom_range(300, 150);
            if (pixels_sent + n_pixels > PIXEL_BUDGET) n_pixels = PIXEL_BUDGET - pixels_sent;
            roll = $urandom_range(99);
            if (roll < 50)      spread = SPREAD_FULL;
            else if (roll < 85) spread = SPREAD_NARROW;
            else                spread = SPREAD_GRAY;
            send_image(n_pixels, spread);
        end
        calm = 0;
        i_valid <= 1'b0;

        while (stats_board.stats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (stats_board.failed) begin
            $display("TB_ERROR");
        end else begin
            $display("TB_OK");
        end
        $finish;
    end

endmodule

/* rgb_histogram_mean_median.f */
rtl/core/rhmm_pkg.sv
rtl/core/rhmm_ram.sv
rtl/core/rhmm_ctrl.sv
rtl/core/rhmm_dp.sv
rtl/core/rgb_histogram_mean_median.sv
tb/sv/rgb_histogram_mean_median_test.sv
